[rtl/text_console_writer_top_assert.svh]
// Assertion macros for the text console writer checker
`ifndef TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define TCW_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcw assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define TCW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcw assertion failed");

`endif

[rtl/tcw_pkg.sv]
// Shared constants and types for the text console writer
package tcw_pkg;

  localparam int SCREEN_COLUMNS_DEF = 80;
  localparam int SCREEN_ROWS_DEF    = 25;

  localparam int CMD_W    = 2;
  localparam int BYTE_W   = 8;
  localparam int COLUMN_W = 7;
  localparam int ROW_W    = 5;
  localparam int LINEAR_W = 11;
  localparam int CELL_W   = 2 * BYTE_W;

  localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'd10;
  localparam logic [BYTE_W-1:0] CHAR_TAB     = 8'd9;
  localparam logic [BYTE_W-1:0] CHAR_BLANK   = 8'd32;
  localparam int                TAB_STOP     = 8;

  localparam logic [BYTE_W-1:0] ATTR_RESET = 8'd7;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_SET   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_RDATA,
    ST_SCROLL,
    ST_BLANK,
    ST_CLEAR
  } state_t;

endpackage

[rtl/text_console_writer_top.sv]
// Text console writer: screen store, cursor and command sequencer
//
// A put character or set cursor transaction goes from input accept through
// ST_EXEC to a registered result, a read cell through ST_EXEC and ST_RDATA,
// since the screen RAM has a registered read and a single write port; ST_EXEC
// waits until the output register is free. A put character that reaches the
// end of the screen scrolls: the RAM is walked one cell per cycle, moving each
// row up and then blanking the last row. Clear screen blanks every cell.
// After reset the RAM is zeroed by a pass over all COLS*ROWS cells during
// which in_ready stays low; cfg_we is taken in any state.
module text_console_writer_top #(
  parameter int SCREEN_COLUMNS = tcw_pkg::SCREEN_COLUMNS_DEF,
  parameter int SCREEN_ROWS    = tcw_pkg::SCREEN_ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [tcw_pkg::BYTE_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tcw_pkg::CMD_W-1:0]     in_command,
  input  logic [tcw_pkg::BYTE_W-1:0]    in_char_code,
  input  logic [tcw_pkg::COLUMN_W-1:0]  in_column,
  input  logic [tcw_pkg::ROW_W-1:0]     in_row,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tcw_pkg::COLUMN_W-1:0]  out_cursor_column,
  output logic [tcw_pkg::ROW_W-1:0]     out_cursor_row,
  output logic [tcw_pkg::LINEAR_W-1:0]  out_cursor_linear,
  output logic                          out_scrolled,
  output logic [tcw_pkg::BYTE_W-1:0]    out_cell_char,
  output logic [tcw_pkg::BYTE_W-1:0]    out_cell_attr
);
  import tcw_pkg::*;

  localparam int CELLS = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int LAST  = CELLS - SCREEN_COLUMNS;
  localparam int CW    = $clog2(SCREEN_COLUMNS);
  localparam int RW    = $clog2(SCREEN_ROWS);
  localparam int AW    = $clog2(CELLS);
  localparam int TBW   = $clog2(TAB_STOP);

  state_t            state_r, state_nxt;
  logic [AW-1:0]     sw_r, sw_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [AW-1:0]     lin_r, lin_nxt;
  logic [BYTE_W-1:0] attr_r;

  cmd_t                cmd_r;
  logic [BYTE_W-1:0]   char_r;
  logic [COLUMN_W-1:0] icol_r;
  logic [ROW_W-1:0]    irow_r;

  logic                out_valid_r, out_valid_nxt;
  logic [COLUMN_W-1:0] out_col_r, out_col_nxt;
  logic [ROW_W-1:0]    out_row_r, out_row_nxt;
  logic [LINEAR_W-1:0] out_lin_r, out_lin_nxt;
  logic                out_scr_r, out_scr_nxt;
  logic [BYTE_W-1:0]   out_char_r, out_char_nxt;
  logic [BYTE_W-1:0]   out_attr_r, out_attr_nxt;

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rdata_r;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_wa, mem_ra;
  logic [CELL_W-1:0] mem_wd;

  logic              out_free;
  logic              load;
  logic              res_scr;
  logic [BYTE_W-1:0] res_char, res_attr;

  // put character cursor math
  logic          is_nl, is_tab, is_write;
  logic [CW:0]   step, col_sum;
  logic          wrap, p_scroll;
  logic [CW-1:0] p_col;
  logic [RW-1:0] p_row;
  logic [AW-1:0] p_lin;

  // clamped position for set cursor and read cell
  logic [31:0]   cin_ext, rin_ext, cc32, rc32;
  logic [CW-1:0] cc;
  logic [RW-1:0] rc;
  logic [AW-1:0] clin;

  // output field extension
  logic [31:0] col_ext, row_ext, lin_ext;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  assign out_cursor_column = out_col_r;
  assign out_cursor_row    = out_row_r;
  assign out_cursor_linear = out_lin_r;
  assign out_scrolled      = out_scr_r;
  assign out_cell_char     = out_char_r;
  assign out_cell_attr     = out_attr_r;

  always_comb begin
    is_nl    = (char_r == CHAR_NEWLINE);
    is_tab   = (char_r == CHAR_TAB);
    is_write = !is_nl && !is_tab;
    if (is_nl) begin
      step = (CW+1)'(SCREEN_COLUMNS) - {1'b0, col_r};
    end else if (is_tab) begin
      step = (CW+1)'(TAB_STOP) - (CW+1)'(lin_r[TBW-1:0]);
    end else begin
      step = (CW+1)'(1);
    end
    col_sum  = {1'b0, col_r} + step;
    wrap     = (col_sum >= (CW+1)'(SCREEN_COLUMNS));
    p_scroll = wrap && (row_r == RW'(SCREEN_ROWS - 1));
    if (wrap) begin
      p_col = CW'(col_sum - (CW+1)'(SCREEN_COLUMNS));
      p_row = row_r + RW'(1);
    end else begin
      p_col = col_sum[CW-1:0];
      p_row = row_r;
    end
    p_lin = lin_r + AW'(step);
  end

  always_comb begin
    cin_ext = 32'(icol_r);
    rin_ext = 32'(irow_r);
    cc32    = (cin_ext > 32'(SCREEN_COLUMNS - 1)) ? 32'(SCREEN_COLUMNS - 1) : cin_ext;
    rc32    = (rin_ext > 32'(SCREEN_ROWS - 1)) ? 32'(SCREEN_ROWS - 1) : rin_ext;
    cc      = cc32[CW-1:0];
    rc      = rc32[RW-1:0];
    clin    = AW'(rc) * AW'(SCREEN_COLUMNS) + AW'(cc);
  end

  always_comb begin
    state_nxt = state_r;
    sw_nxt    = sw_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    lin_nxt   = lin_r;
    mem_we    = 1'b0;
    mem_wa    = sw_r;
    mem_wd    = {attr_r, CHAR_BLANK};
    mem_re    = 1'b0;
    mem_ra    = sw_r;
    load      = 1'b0;
    res_scr   = 1'b0;
    res_char  = '0;
    res_attr  = '0;
    case (state_r)
      ST_INIT: begin
        mem_we = 1'b1;
        mem_wd = '0;
        if (sw_r == AW'(CELLS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          sw_nxt = sw_r + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          case (cmd_r)
            CMD_PUT: begin
              if (is_write) begin
                mem_we = 1'b1;
                mem_wa = lin_r;
                mem_wd = {attr_r, char_r};
              end
              if (p_scroll) begin
                col_nxt   = '0;
                row_nxt   = RW'(SCREEN_ROWS - 1);
                lin_nxt   = AW'(LAST);
                sw_nxt    = '0;
                state_nxt = ST_SCROLL;
              end else begin
                col_nxt   = p_col;
                row_nxt   = p_row;
                lin_nxt   = p_lin;
                load      = 1'b1;
                state_nxt = ST_IDLE;
              end
            end
            CMD_SET: begin
              col_nxt   = cc;
              row_nxt   = rc;
              lin_nxt   = clin;
              load      = 1'b1;
              state_nxt = ST_IDLE;
            end
            CMD_CLEAR: begin
              col_nxt   = '0;
              row_nxt   = '0;
              lin_nxt   = '0;
              sw_nxt    = '0;
              state_nxt = ST_CLEAR;
            end
            CMD_READ: begin
              mem_re    = 1'b1;
              mem_ra    = clin;
              state_nxt = ST_RDATA;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_RDATA: begin
        load      = 1'b1;
        res_char  = rdata_r[BYTE_W-1:0];
        res_attr  = rdata_r[CELL_W-1:BYTE_W];
        state_nxt = ST_IDLE;
      end
      ST_SCROLL: begin
        // read one row below, write back the cell from the previous read
        mem_re = (sw_r < AW'(LAST));
        mem_ra = sw_r + AW'(SCREEN_COLUMNS);
        mem_we = (sw_r != '0);
        mem_wa = sw_r - AW'(1);
        mem_wd = rdata_r;
        if (sw_r == AW'(LAST)) begin
          state_nxt = ST_BLANK;
        end else begin
          sw_nxt = sw_r + AW'(1);
        end
      end
      ST_BLANK: begin
        mem_we = 1'b1;
        if (sw_r == AW'(CELLS - 1)) begin
          load      = 1'b1;
          res_scr   = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          sw_nxt = sw_r + AW'(1);
        end
      end
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (sw_r == AW'(CELLS - 1)) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          sw_nxt = sw_r + AW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    col_ext       = 32'(col_nxt);
    row_ext       = 32'(row_nxt);
    lin_ext       = 32'(lin_nxt);
    out_valid_nxt = out_valid_r && !out_ready;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_lin_nxt   = out_lin_r;
    out_scr_nxt   = out_scr_r;
    out_char_nxt  = out_char_r;
    out_attr_nxt  = out_attr_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_col_nxt   = col_ext[COLUMN_W-1:0];
      out_row_nxt   = row_ext[ROW_W-1:0];
      out_lin_nxt   = lin_ext[LINEAR_W-1:0];
      out_scr_nxt   = res_scr;
      out_char_nxt  = res_char;
      out_attr_nxt  = res_attr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      sw_r        <= '0;
      col_r       <= '0;
      row_r       <= '0;
      lin_r       <= '0;
      attr_r      <= ATTR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sw_r        <= sw_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      lin_r       <= lin_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        attr_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r  <= cmd_t'(in_command);
      char_r <= in_char_code;
      icol_r <= in_column;
      irow_r <= in_row;
    end
    out_col_r  <= out_col_nxt;
    out_row_r  <= out_row_nxt;
    out_lin_r  <= out_lin_nxt;
    out_scr_r  <= out_scr_nxt;
    out_char_r <= out_char_nxt;
    out_attr_r <= out_attr_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_ra];
    end
  end

endmodule

[rtl/tcw_checker.sv]
// Port-level checker for the text console writer, bound to the top level
`include "text_console_writer_top_assert.svh"

module tcw_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [tcw_pkg::COLUMN_W-1:0]  out_cursor_column,
  input logic [tcw_pkg::LINEAR_W-1:0]  out_cursor_linear,
  input logic                          out_scrolled
);

  `TCW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `TCW_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_cursor_linear))
  `TCW_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
  `TCW_ASSERT_NOW(a_scroll_col0, out_valid && out_scrolled, out_cursor_column == '0)

endmodule

bind text_console_writer_top tcw_checker u_tcw_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_cursor_column (out_cursor_column),
  .out_cursor_linear (out_cursor_linear),
  .out_scrolled      (out_scrolled)
);
